/* hw/rtl/recent_event_window_counter_assert.svh */
// assertion macros shared by the recent event window counter rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef RECENT_EVENT_WINDOW_COUNTER_ASSERT_SVH
`define RECENT_EVENT_WINDOW_COUNTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define REWC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define REWC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/rewc_pkg.sv */
// shared types and constants for the recent event window counter
// no dependencies
`default_nettype none

package rewc_pkg;

	localparam int TIME_W         = 31;
	localparam int RCOUNT_W       = 7;
	localparam int DEPTH_DEFAULT  = 64;
	localparam logic [TIME_W-1:0] WINDOW_RESET = 31'd3000;

	typedef struct packed {
		logic [RCOUNT_W-1:0] recent_count;
		logic                count_saturated;
	} rewc_res_t;

endpackage

`default_nettype wire

/* hw/rtl/rewc_core.sv */
// history ring memory and backward walk over stored timestamps
// depends on rewc_pkg and recent_event_window_counter_assert.svh
`default_nettype none

`include "recent_event_window_counter_assert.svh"

module rewc_core
	import rewc_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TIME_W-1:0] time_in,
	input  wire logic [TIME_W-1:0] window,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output rewc_res_t              res
);

	localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] ONE_CNT   = CW'(1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

	state_t              state_q;
	logic [TIME_W-1:0]   mem [HISTORY_DEPTH];
	logic [PW-1:0]       newest_q;
	logic [CW-1:0]       stored_q;
	logic [CW-1:0]       issue_left_q;
	logic [CW-1:0]       count_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [TIME_W-1:0]   time_q;
	logic                pend_s1;
	logic                last_s1;
	logic [TIME_W-1:0]   rd_data_s1;

	logic [PW-1:0]       next_slot;
	logic [CW-1:0]       stored_nx;
	logic [PW-1:0]       rd_addr;
	logic                issue;
	logic [TIME_W:0]     age;
	logic                in_win;
	logic                walk_done;
	logic [31:0]         count_ext;

	assign next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + PW'(1);
	assign stored_nx = (stored_q == FULL_CNT) ? stored_q : stored_q + ONE_CNT;
	assign rd_addr   = (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - PW'(1);

	// signed age, new minus stored
	assign age       = {1'b0, time_q} - {1'b0, rd_data_s1};
	assign in_win    = $signed(age) <= $signed({1'b0, window});
	assign walk_done = pend_s1 && (!in_win || last_s1);
	assign issue     = (state_q == ST_WALK) && (issue_left_q != '0) && !walk_done;

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign count_ext = 32'(count_q);
	assign res.recent_count    = count_ext[RCOUNT_W-1:0];
	assign res.count_saturated = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (start) begin
			mem[next_slot] <= time_in;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			last_s1    <= (issue_left_q == ONE_CNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			newest_q     <= '0;
			stored_q     <= '0;
			issue_left_q <= '0;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			time_q       <= '0;
			pend_s1      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						newest_q     <= next_slot;
						stored_q     <= stored_nx;
						issue_left_q <= stored_nx - ONE_CNT;
						rd_ptr_q     <= next_slot;
						count_q      <= ONE_CNT;
						time_q       <= time_in;
						state_q      <= (stored_nx == ONE_CNT) ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_ptr_q     <= rd_addr;
						issue_left_q <= issue_left_q - ONE_CNT;
					end
					if (pend_s1 && in_win) begin
						count_q <= count_q + ONE_CNT;
					end
					if (walk_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					pend_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	`REWC_ASSERT_NOW(a_start_when_idle, start, state_q == ST_IDLE)
	`REWC_ASSERT_NOW(a_count_bounded, state_q != ST_IDLE, count_q <= stored_q)
	`REWC_ASSERT_NOW(a_read_only_in_walk, pend_s1, state_q == ST_WALK)
	`REWC_ASSERT_NOW(a_sat_needs_full, res_valid && res.count_saturated, stored_q == FULL_CNT)
	`REWC_ASSERT_NEXT(a_walk_ends_done, (state_q == ST_WALK) && walk_done, state_q == ST_DONE)

endmodule

`default_nettype wire

/* hw/rtl/recent_event_window_counter.sv */
// channel        dir  width  contents
// s_axis         in   32     time_stamp [30:0]
// m_axis         out  8      recent_count [6:0], count_saturated [7]
// cfg            in   32     window_length [30:0]
// an event walks back over the older entries in the history, and the walk reads
// the history memory one entry per cycle
// a new event is taken once the walk result has moved to the output register,
// so a full output register held by m_axis_tready stalls s_axis_tready
// asynchronous reset empties the history and sets window_length to 3000
// top level with the window register and output register, depends on rewc_pkg and rewc_core
`default_nettype none

module recent_event_window_counter
	import rewc_pkg::*;
#(
	parameter int HISTORY_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // time_stamp [30:0], zero pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // recent_count [6:0], count_saturated [7]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data        // window_length [30:0], zero pad
);

	logic [TIME_W-1:0] window_q;
	logic              core_idle;
	logic              res_valid;
	logic              res_ready;
	rewc_res_t         res;
	rewc_res_t         out_q;
	logic              out_valid_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = core_idle;
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.count_saturated, out_q.recent_count};

	rewc_core #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_axis_tvalid && s_axis_tready),
		.time_in  (s_axis_tdata[TIME_W-1:0]),
		.window   (window_q),
		.idle     (core_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data[TIME_W-1:0];
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
